// ===== src/fdr_pkg.sv =====
// Shared types, constants and helpers for the frame dirty-rectangle flush block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fdr_pkg;

    // Largest frame the stores are sized for.
    localparam int unsigned MAX_WIDTH  = 320;
    localparam int unsigned MAX_HEIGHT = 240;

    localparam int unsigned X_W    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned Y_W    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH + 1);

    // Queue between the front and the back, and the result queue.
    // Both depths are powers of two so the pointers wrap by themselves.
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = X_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd3;

    // Flush actions.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_FULL  = 2'd1;
    localparam logic [1:0] ACT_RECT  = 2'd2;
    localparam logic [1:0] ACT_DEFER = 2'd3;

    typedef struct packed {
        logic [31:0] argb;
        logic        last_pixel;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [15:0]    rgb565;
        logic           changed;
        logic           frame_done;
        logic [1:0]     flush_action;
        logic [X_W-1:0] rect_x;
        logic [Y_W-1:0] rect_y;
        logic [X_W-1:0] rect_w;
        logic [Y_W-1:0] rect_h;
    } t_out_item;

    // Configuration as the datapath sees it, with the frame size clamped.
    typedef struct packed {
        logic           flush_mode;
        logic [X_W-1:0] width;
        logic [Y_W-1:0] height;
        logic [7:0]     min_interval;
    } t_cfg;

    // Side effects of a configuration write.
    typedef struct packed {
        logic any_wr;
        logic dim_wr;
    } t_cfg_evt;

    // A pixel with its place in the frame, from the front to the back.
    typedef struct packed {
        logic [31:0]       argb;
        logic              last;
        logic [31:0]       now_ms;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [ADDR_W-1:0] addr;
    } t_pix;

    // A compared pixel with the dirty box as it stands after it.
    typedef struct packed {
        logic [15:0]    rgb565;
        logic           changed;
        logic           last;
        logic [31:0]    now_ms;
        logic           first;
        logic           dirty;
        logic [X_W-1:0] min_x;
        logic [X_W-1:0] max_x;
        logic [Y_W-1:0] min_y;
        logic [Y_W-1:0] max_y;
    } t_chk;

    function automatic logic [15:0] to_rgb565(input logic [31:0] p);
        return {p[23:19], p[15:10], p[7:3]};
    endfunction

endpackage

`default_nettype wire

// ===== src/fdr_front.sv =====
// Front end: accepts pixels, tracks the raster position and shadow address,
// and queues them for the back end. Depends on fdr_pkg.
`default_nettype none

module fdr_front import fdr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    input  wire t_cfg     i_cfg,
    input  wire t_cfg_evt i_evt,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_pix          o_pix
);

    logic [X_W-1:0]    r_col, n_col;
    logic [Y_W-1:0]    r_row, n_row;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_pix              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              accept;
    logic              col_end, row_end;
    t_pix              pix;

    assign accept  = i_push && !o_full;
    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_pix   = r_q[r_rd];

    always_comb begin
        col_end = (({1'b0, r_col} + (X_W + 1)'(1)) >= {1'b0, i_cfg.width});
        row_end = (({1'b0, r_row} + (Y_W + 1)'(1)) >= {1'b0, i_cfg.height});

        pix.argb   = i_item.argb;
        pix.last   = i_item.last_pixel;
        pix.now_ms = i_item.now_ms;
        pix.x      = r_col;
        pix.y      = r_row;
        pix.addr   = r_addr;

        // The address follows the raster, so row * width + column is kept as a count.
        priority if (i_item.last_pixel || (col_end && row_end)) begin
            n_col  = '0;
            n_row  = '0;
            n_addr = '0;
        end else if (col_end) begin
            n_col  = '0;
            n_row  = r_row + 1'b1;
            n_addr = r_addr + 1'b1;
        end else begin
            n_col  = r_col + 1'b1;
            n_row  = r_row;
            n_addr = r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_evt.dim_wr) begin
                r_col  <= '0;
                r_row  <= '0;
                r_addr <= '0;
            end else if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_addr <= n_addr;
            end
            if (accept) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(accept) - (QPTR_W + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= pix;
        end
    end

    // The position never leaves the active frame.
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < i_cfg.width) && (r_row < i_cfg.height))
        else $error("raster position outside the active frame");

endmodule

`default_nettype wire

// ===== src/fdr_diff.sv =====
// Back end, first half: reads the shadow frame, compares, writes back changed
// pixels to the shadow and panel stores and grows the dirty box. Depends on fdr_pkg.
`default_nettype none

module fdr_diff import fdr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg_evt          i_evt,
    input  wire logic              i_empty,
    input  wire t_pix              i_pix,
    output logic                   o_pop,
    input  wire logic [OPTR_W:0]   i_out_level,
    output logic                   o_valid,
    output t_chk                   o_chk
);

    logic [31:0] r_shadow [DEPTH];
    logic [15:0] r_panel  [DEPTH];

    logic           r_a_valid, r_b_valid;
    t_pix           r_a;
    logic [31:0]    r_rd_data;
    logic           r_fwd;
    logic [31:0]    r_fwd_data;
    t_chk           r_b;

    logic           r_ready;
    logic           r_dirty;
    logic [X_W-1:0] r_min_x, r_max_x;
    logic [Y_W-1:0] r_min_y, r_max_y;

    logic [31:0]    cur;
    logic           changed;
    logic           wr_en;
    logic [15:0]    c565;
    logic [OPTR_W+1:0] slots;
    t_chk           chk;

    // Only issue a pixel when the result queue has room for it and everything in flight.
    assign slots   = {1'b0, i_out_level} + (OPTR_W + 2)'(r_a_valid) + (OPTR_W + 2)'(r_b_valid);
    assign o_pop   = !i_empty && (slots < (OPTR_W + 2)'(OUT_DEPTH));
    assign o_valid = r_b_valid;
    assign o_chk   = r_b;

    always_comb begin
        cur     = r_fwd ? r_fwd_data : r_rd_data;
        changed = !r_ready || (cur != r_a.argb);
        wr_en   = r_a_valid && changed;
        c565    = to_rgb565(r_a.argb);

        chk.rgb565  = c565;
        chk.changed = changed;
        chk.last    = r_a.last;
        chk.now_ms  = r_a.now_ms;
        chk.first   = !r_ready;
        chk.dirty   = r_dirty;
        chk.min_x   = r_min_x;
        chk.max_x   = r_max_x;
        chk.min_y   = r_min_y;
        chk.max_y   = r_max_y;
        if (changed && r_ready) begin
            chk.dirty = 1'b1;
            if (!r_dirty) begin
                chk.min_x = r_a.x;
                chk.max_x = r_a.x;
                chk.min_y = r_a.y;
                chk.max_y = r_a.y;
            end else begin
                if (r_a.x < r_min_x) chk.min_x = r_a.x;
                if (r_a.x > r_max_x) chk.max_x = r_a.x;
                if (r_a.y < r_min_y) chk.min_y = r_a.y;
                if (r_a.y > r_max_y) chk.max_y = r_a.y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_ready   <= 1'b0;
            r_dirty   <= 1'b0;
            r_min_x   <= '0;
            r_max_x   <= '0;
            r_min_y   <= '0;
            r_max_y   <= '0;
        end else begin
            r_a_valid <= o_pop;
            r_b_valid <= r_a_valid;
            if (i_evt.dim_wr) begin
                r_ready <= 1'b0;
                r_dirty <= 1'b0;
                r_min_x <= '0;
                r_max_x <= '0;
                r_min_y <= '0;
                r_max_y <= '0;
            end else if (r_a_valid) begin
                if (r_a.last) begin
                    r_ready <= 1'b1;
                    r_dirty <= 1'b0;
                    r_min_x <= '0;
                    r_max_x <= '0;
                    r_min_y <= '0;
                    r_max_y <= '0;
                end else begin
                    r_dirty <= chk.dirty;
                    r_min_x <= chk.min_x;
                    r_max_x <= chk.max_x;
                    r_min_y <= chk.min_y;
                    r_max_y <= chk.max_y;
                end
            end
        end
    end

    // Shadow and panel stores. A read that meets a write to the same entry in
    // the same cycle takes the written value through the bypass register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a        <= i_pix;
            r_rd_data  <= r_shadow[i_pix.addr];
            r_fwd      <= wr_en && (i_pix.addr == r_a.addr);
            r_fwd_data <= r_a.argb;
        end
        if (wr_en) begin
            r_shadow[r_a.addr] <= r_a.argb;
            r_panel[r_a.addr]  <= c565;
        end
        if (r_a_valid) begin
            r_b <= chk;
        end
    end

    // A dirty box is never inverted.
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty |-> (r_min_x <= r_max_x) && (r_min_y <= r_max_y))
        else $error("dirty box inverted");

endmodule

`default_nettype wire

// ===== src/fdr_flush.sv =====
// Back end, second half: the flush policy with its pending box and timing,
// and the result queue. Depends on fdr_pkg.
`default_nettype none

module fdr_flush import fdr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_cfg_evt i_evt,
    input  wire logic     i_valid,
    input  wire t_chk     i_chk,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_out_item     o_item,
    output logic [OPTR_W:0] o_level
);

    logic              r_pending, n_pending;
    logic [X_W-1:0]    r_pmin_x, n_pmin_x, r_pmax_x, n_pmax_x;
    logic [Y_W-1:0]    r_pmin_y, n_pmin_y, r_pmax_y, n_pmax_y;
    logic [31:0]       r_last_flush, n_last_flush;
    logic              r_flushed_once, n_flushed_once;
    logic [ADDR_W-1:0] r_total;

    t_out_item         r_out [OUT_DEPTH];
    logic [OPTR_W-1:0] r_wr, r_rd;
    logic [OPTR_W:0]   r_cnt;

    logic [31:0]       elapsed;
    logic              passed;
    logic [X_W-1:0]    bw;
    logic [Y_W-1:0]    bh;
    logic [ADDR_W-1:0] area;
    logic              small_area, big_area;
    logic [X_W-1:0]    u_min_x, u_max_x;
    logic [Y_W-1:0]    u_min_y, u_max_y;
    logic              do_flush;
    t_out_item         res;

    assign o_empty = (r_cnt == '0);
    assign o_item  = r_out[r_rd];
    assign o_level = r_cnt;

    always_comb begin
        elapsed = i_chk.now_ms - r_last_flush;
        passed  = !r_flushed_once || (elapsed >= {24'b0, i_cfg.min_interval});
        bw      = i_chk.max_x - i_chk.min_x + 1'b1;
        bh      = i_chk.max_y - i_chk.min_y + 1'b1;
        area    = ADDR_W'(bw) * ADDR_W'(bh);
        // area <= total/8 and area > total/3, without dividing.
        small_area = {area, 3'b000} <= {3'b000, r_total};
        big_area   = ({2'b00, area} + {1'b0, area, 1'b0}) > {2'b00, r_total};

        // The box taken together with the pending box, if any.
        u_min_x = i_chk.min_x;
        u_max_x = i_chk.max_x;
        u_min_y = i_chk.min_y;
        u_max_y = i_chk.max_y;
        if (r_pending) begin
            if (r_pmin_x < u_min_x) u_min_x = r_pmin_x;
            if (r_pmax_x > u_max_x) u_max_x = r_pmax_x;
            if (r_pmin_y < u_min_y) u_min_y = r_pmin_y;
            if (r_pmax_y > u_max_y) u_max_y = r_pmax_y;
        end

        n_pending      = r_pending;
        n_pmin_x       = r_pmin_x;
        n_pmax_x       = r_pmax_x;
        n_pmin_y       = r_pmin_y;
        n_pmax_y       = r_pmax_y;
        do_flush       = 1'b0;

        res.rgb565       = i_chk.rgb565;
        res.changed      = i_chk.changed;
        res.frame_done   = i_chk.last;
        res.flush_action = ACT_NONE;
        res.rect_x       = '0;
        res.rect_y       = '0;
        res.rect_w       = '0;
        res.rect_h       = '0;

        if (i_chk.last) begin
            priority if (i_chk.first) begin
                res.flush_action = ACT_FULL;
                res.rect_w       = i_cfg.width;
                res.rect_h       = i_cfg.height;
                do_flush         = 1'b1;
            end else if (!i_chk.dirty) begin
                if (r_pending && passed) begin
                    res.flush_action = ACT_RECT;
                    res.rect_x       = r_pmin_x;
                    res.rect_y       = r_pmin_y;
                    res.rect_w       = r_pmax_x - r_pmin_x + 1'b1;
                    res.rect_h       = r_pmax_y - r_pmin_y + 1'b1;
                    do_flush         = 1'b1;
                end
            end else if (i_cfg.flush_mode) begin
                res.flush_action = ACT_FULL;
                res.rect_w       = i_cfg.width;
                res.rect_h       = i_cfg.height;
                do_flush         = 1'b1;
            end else if (!passed && small_area) begin
                n_pending        = 1'b1;
                n_pmin_x         = u_min_x;
                n_pmax_x         = u_max_x;
                n_pmin_y         = u_min_y;
                n_pmax_y         = u_max_y;
                res.flush_action = ACT_DEFER;
                res.rect_x       = u_min_x;
                res.rect_y       = u_min_y;
                res.rect_w       = u_max_x - u_min_x + 1'b1;
                res.rect_h       = u_max_y - u_min_y + 1'b1;
            end else if (big_area) begin
                res.flush_action = ACT_FULL;
                res.rect_w       = i_cfg.width;
                res.rect_h       = i_cfg.height;
                do_flush         = 1'b1;
            end else begin
                res.flush_action = ACT_RECT;
                res.rect_x       = u_min_x;
                res.rect_y       = u_min_y;
                res.rect_w       = u_max_x - u_min_x + 1'b1;
                res.rect_h       = u_max_y - u_min_y + 1'b1;
                do_flush         = 1'b1;
            end
        end

        n_last_flush   = do_flush ? i_chk.now_ms : r_last_flush;
        n_flushed_once = r_flushed_once || do_flush;
        if (do_flush) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= 1'b0;
            r_pmin_x       <= '0;
            r_pmax_x       <= '0;
            r_pmin_y       <= '0;
            r_pmax_y       <= '0;
            r_last_flush   <= '0;
            r_flushed_once <= 1'b0;
            r_wr           <= '0;
            r_rd           <= '0;
            r_cnt          <= '0;
        end else begin
            if (i_evt.any_wr) begin
                r_pending <= 1'b0;
                if (i_evt.dim_wr) begin
                    r_flushed_once <= 1'b0;
                end
            end else if (i_valid) begin
                r_pending      <= n_pending;
                r_pmin_x       <= n_pmin_x;
                r_pmax_x       <= n_pmax_x;
                r_pmin_y       <= n_pmin_y;
                r_pmax_y       <= n_pmax_y;
                r_last_flush   <= n_last_flush;
                r_flushed_once <= n_flushed_once;
            end
            if (i_valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (OPTR_W + 1)'(i_valid) - (OPTR_W + 1)'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= ADDR_W'(i_cfg.width) * ADDR_W'(i_cfg.height);
        if (i_valid) begin
            r_out[r_wr] <= res;
        end
    end

    // The issue credit keeps the result queue from overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_cnt != (OPTR_W + 1)'(OUT_DEPTH)))
        else $error("result queue overflow");

    // A pending box only exists after a flush has set the time base.
    a_pending_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_flushed_once)
        else $error("pending box without a flush time");

    // Flush decisions only appear on the last pixel of a frame.
    a_action_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_item.flush_action != ACT_NONE)) |-> o_item.frame_done)
        else $error("flush action on a pixel that is not the last");

endmodule

`default_nettype wire

// ===== src/frame_dirty_rect_flush_policy.sv =====
// Top level of the frame dirty-rectangle flush block: configuration registers
// and the front, diff and flush parts. Depends on fdr_pkg, fdr_front, fdr_diff, fdr_flush.
//
// Pixels enter as beats on the input queue port: a beat is taken at a rising
// edge with i_push high and o_full low, ARGB pixels in raster order, with
// last_pixel marking the end of a frame and now_ms giving the time for it.
// Every pixel beat yields exactly one result beat on the output queue port,
// shown while o_empty is low and taken at an edge with i_pop high. The result
// carries the RGB565 pixel, its changed flag and, on the last pixel, the flush
// decision: none, full refresh, a rectangle, or a deferral with the pending box.
// A beat passes through the front queue, the diff registers r_a and r_b and the
// result queue before it can be popped. The block sustains one pixel per cycle
// while the receiver keeps popping; the rate is set by the single shadow memory,
// read once and written at most once per pixel in the diff pipeline.
// The user must write configuration through i_cfg_we, i_cfg_idx and i_cfg_data only
// while the block is idle; the block does not enforce this. A width or height write
// restarts the frame and makes the next frame a first frame with a full refresh.
// After reset the configuration returns to its defaults and all control state
// clears; the shadow and panel stores hold garbage until the first frame fills
// them, which needs no clearing pass. If the receiver stalls, up to four results
// wait in the result queue, then the front queue fills with four more pixels
// and o_full rises until results are popped again.
`default_nettype none

module frame_dirty_rect_flush_policy import fdr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_in_item              i_item,
    output logic                       o_full,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output t_out_item                  o_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic           r_flush_mode;
    logic [X_W-1:0] r_width;
    logic [Y_W-1:0] r_height;
    logic [7:0]     r_min_interval;

    t_cfg           cfg;
    t_cfg_evt       evt;

    logic           q_pop;
    logic           q_empty;
    t_pix           q_pix;
    logic           chk_valid;
    t_chk           chk;
    logic [OPTR_W:0] out_level;

    // The frame size in use is held within 1..MAX in each direction.
    always_comb begin
        cfg.flush_mode   = r_flush_mode;
        cfg.min_interval = r_min_interval;
        if (r_width == '0) begin
            cfg.width = X_W'(1);
        end else if (r_width > X_W'(MAX_WIDTH)) begin
            cfg.width = X_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == '0) begin
            cfg.height = Y_W'(1);
        end else if (r_height > Y_W'(MAX_HEIGHT)) begin
            cfg.height = Y_W'(MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end

        // Every write drops the pending box; a size write also restarts the frame.
        evt.any_wr = i_cfg_we;
        evt.dim_wr = i_cfg_we && ((i_cfg_idx == CFG_WIDTH) || (i_cfg_idx == CFG_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_mode   <= 1'b0;
            r_width        <= X_W'(320);
            r_height       <= Y_W'(240);
            r_min_interval <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLUSH_MODE:   r_flush_mode   <= i_cfg_data[0];
                CFG_WIDTH:        r_width        <= i_cfg_data[X_W-1:0];
                CFG_HEIGHT:       r_height       <= i_cfg_data[Y_W-1:0];
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[7:0];
                default:          r_flush_mode   <= r_flush_mode;
            endcase
        end
    end

    fdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .i_cfg   (cfg),
        .i_evt   (evt),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_pix   (q_pix)
    );

    fdr_diff u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_empty     (q_empty),
        .i_pix       (q_pix),
        .o_pop       (q_pop),
        .i_out_level (out_level),
        .o_valid     (chk_valid),
        .o_chk       (chk)
    );

    fdr_flush u_flush (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_evt   (evt),
        .i_valid (chk_valid),
        .i_chk   (chk),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_item  (o_item),
        .o_level (out_level)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for frame_dirty_rect_flush_policy: pixel stimulus, a running
// prediction of the dirty box and flush decision, and a result scoreboard.
// Depends on fdr_pkg and the block's RTL only.
module tb_top import fdr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // The run is cut off here.
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned RANDOM_BEATS = 900;
    localparam int unsigned PRINT_LIMIT  = 40;

    // Scoreboard. It follows the block's state beat by beat: the shadow frame,
    // the dirty box of the frame in progress, the pending box and the flush
    // timing. Each accepted pixel beat yields one expected result beat, queued
    // in acceptance order and compared with the result beats as they are popped.
    class flush_scoreboard;
        bit [31:0]   shadow [DEPTH];
        bit          written [DEPTH];
        bit          mode_full;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned interval_reg;
        bit          ready;
        bit          dirty;
        bit          pending;
        bit          flushed_once;
        int unsigned col, row;
        int unsigned bx0, bx1, by0, by1;
        int unsigned px0, px1, py0, py1;
        bit [31:0]   last_flush_ms;
        t_out_item   expected_beats[$];
        int unsigned error_count;

        function new();
            width_reg    = MAX_WIDTH;
            height_reg   = MAX_HEIGHT;
            interval_reg = 16;
        endfunction

        // Frame size as the block uses it: held within 1..MAX.
        function int unsigned frame_w();
            if (width_reg == 0) return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned frame_h();
            if (height_reg == 0) return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        // Shadow index of the next pixel, or of the one after it.
        function int unsigned pixel_index(bit ahead);
            int unsigned w, h, x, y;
            w = frame_w();
            h = frame_h();
            x = (col >= w) ? 0 : col;
            y = (row >= h) ? 0 : row;
            if (ahead) begin
                if (x + 1 >= w) begin
                    x = 0;
                    y = (y + 1 >= h) ? 0 : y + 1;
                end else begin
                    x = x + 1;
                end
            end
            return y * w + x;
        endfunction

        function void restart();
            col   = 0;
            row   = 0;
            bx0   = 0;
            bx1   = 0;
            by0   = 0;
            by1   = 0;
            dirty = 0;
        endfunction

        function void record_flush(bit [31:0] now);
            pending       = 0;
            last_flush_ms = now;
            flushed_once  = 1;
        endfunction

        function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            pending = 0;
            case (idx)
                CFG_FLUSH_MODE: begin
                    mode_full = data[0];
                end
                CFG_MIN_INTERVAL: begin
                    interval_reg = data[7:0];
                end
                CFG_WIDTH, CFG_HEIGHT: begin
                    if (idx == CFG_WIDTH) width_reg = data;
                    else height_reg = data[7:0];
                    ready        = 0;
                    flushed_once = 0;
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void note_pixel(t_in_item beat);
            int unsigned w, h, x, y, idx, total, area;
            int unsigned rx, ry, rw, rh, x0, x1, y0, y1;
            bit          chg, passed;
            bit [31:0]   elapsed;
            logic [1:0]  act;
            t_out_item   exp_beat;
            w = frame_w();
            h = frame_h();
            if (col >= w) col = 0;
            if (row >= h) row = 0;
            x   = col;
            y   = row;
            idx = y * w + x;

            chg = !ready || (shadow[idx] != beat.argb);
            if (chg) begin
                shadow[idx]  = beat.argb;
                written[idx] = 1;
                // The box only grows once the shadow holds a whole frame.
                if (ready) begin
                    if (!dirty) begin
                        bx0   = x;
                        bx1   = x;
                        by0   = y;
                        by1   = y;
                        dirty = 1;
                    end else begin
                        if (x < bx0) bx0 = x;
                        if (x > bx1) bx1 = x;
                        if (y < by0) by0 = y;
                        if (y > by1) by1 = y;
                    end
                end
            end

            if (x + 1 >= w) begin
                col = 0;
                row = (y + 1 >= h) ? 0 : y + 1;
            end else begin
                col = x + 1;
            end

            act = ACT_NONE;
            rx  = 0;
            ry  = 0;
            rw  = 0;
            rh  = 0;
            if (beat.last_pixel) begin
                total   = w * h;
                elapsed = beat.now_ms - last_flush_ms;
                passed  = !flushed_once || (elapsed >= interval_reg);
                if (!ready) begin
                    ready = 1;
                    act   = ACT_FULL;
                    rw    = w;
                    rh    = h;
                    record_flush(beat.now_ms);
                end else if (!dirty) begin
                    if (pending && passed) begin
                        act = ACT_RECT;
                        rx  = px0;
                        ry  = py0;
                        rw  = px1 - px0 + 1;
                        rh  = py1 - py0 + 1;
                        record_flush(beat.now_ms);
                    end
                end else begin
                    area = (bx1 - bx0 + 1) * (by1 - by0 + 1);
                    if (mode_full) begin
                        act = ACT_FULL;
                        rw  = w;
                        rh  = h;
                        record_flush(beat.now_ms);
                    end else if (!passed && area <= total / 8) begin
                        if (!pending) begin
                            px0 = bx0;
                            px1 = bx1;
                            py0 = by0;
                            py1 = by1;
                        end else begin
                            if (bx0 < px0) px0 = bx0;
                            if (bx1 > px1) px1 = bx1;
                            if (by0 < py0) py0 = by0;
                            if (by1 > py1) py1 = by1;
                        end
                        pending = 1;
                        act     = ACT_DEFER;
                        rx      = px0;
                        ry      = py0;
                        rw      = px1 - px0 + 1;
                        rh      = py1 - py0 + 1;
                    end else if (area > total / 3) begin
                        act = ACT_FULL;
                        rw  = w;
                        rh  = h;
                        record_flush(beat.now_ms);
                    end else begin
                        x0 = bx0;
                        x1 = bx1;
                        y0 = by0;
                        y1 = by1;
                        if (pending) begin
                            if (px0 < x0) x0 = px0;
                            if (px1 > x1) x1 = px1;
                            if (py0 < y0) y0 = py0;
                            if (py1 > y1) y1 = py1;
                        end
                        act = ACT_RECT;
                        rx  = x0;
                        ry  = y0;
                        rw  = x1 - x0 + 1;
                        rh  = y1 - y0 + 1;
                        record_flush(beat.now_ms);
                    end
                end
                restart();
            end

            exp_beat.rgb565       = {beat.argb[23:19], beat.argb[15:10], beat.argb[7:3]};
            exp_beat.changed      = chg;
            exp_beat.frame_done   = beat.last_pixel;
            exp_beat.flush_action = act;
            exp_beat.rect_x       = rx[X_W-1:0];
            exp_beat.rect_y       = ry[Y_W-1:0];
            exp_beat.rect_w       = rw[X_W-1:0];
            exp_beat.rect_h       = rh[Y_W-1:0];
            expected_beats.push_back(exp_beat);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                if (error_count < PRINT_LIMIT)
                    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_beats.size() == 0) begin
                if (error_count < PRINT_LIMIT)
                    $display("%0t ns: result beat with none expected, expected nothing, actual %h",
                             $time, got);
                error_count++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("rgb565", want.rgb565, got.rgb565);
            compare_field("changed", want.changed, got.changed);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("flush_action", want.flush_action, got.flush_action);
            compare_field("rect_x", want.rect_x, got.rect_x);
            compare_field("rect_y", want.rect_y, got.rect_y);
            compare_field("rect_w", want.rect_w, got.rect_w);
            compare_field("rect_h", want.rect_h, got.rect_h);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    t_in_item              i_item;
    logic                  o_full;
    logic                  o_empty;
    logic                  i_pop;
    t_out_item             o_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    flush_scoreboard sb;
    bit              idle_on;
    bit [31:0]       clock_ms;
    int unsigned     pixels_sent;
    int unsigned     cycle_count;

    frame_dirty_rect_flush_policy u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .o_full     (o_full),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Idle length for either side. Most gaps are short, a few are long, and
    // whole phases run with no gaps at all when idle_on is cleared.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item pixel(bit [31:0] argb, bit last, bit [31:0] now);
        t_in_item beat;
        beat.argb       = argb;
        beat.last_pixel = last;
        beat.now_ms     = now;
        return beat;
    endfunction

    // Drives one pixel beat and returns at the edge that accepts it. Push is
    // left high so that the next beat can follow with no bubble; it is only
    // lowered at a falling edge where no new beat is raised.
    task automatic send_pixel(t_in_item beat);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sb.note_pixel(beat);
        pixels_sent++;
    endtask

    // Stops pushing and waits until every expected result beat has been popped.
    // Every pixel gives a result, so the block is idle at that point.
    task automatic drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.apply_cfg(idx, value[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one frame of up to len pixels. In a first frame every pixel is
    // random; otherwise pixels repeat the shadow except inside the given box,
    // where hit_pct percent of them change. Once the shadow is ready the frame
    // is ended early rather than step onto an entry no first frame has written.
    task automatic send_frame(int unsigned len, int unsigned x0, int unsigned x1,
                              int unsigned y0, int unsigned y1, int unsigned hit_pct,
                              bit [31:0] stamp);
        int unsigned w, idx, x, y, n;
        bit          hit;
        t_in_item    beat;
        for (n = 0; n < len; n++) begin
            w   = sb.frame_w();
            idx = sb.pixel_index(1'b0);
            x   = idx % w;
            y   = idx / w;
            hit = (x >= x0) && (x <= x1) && (y >= y0) && (y <= y1)
                  && ($urandom_range(1, 100) <= hit_pct);
            beat.argb = sb.shadow[idx];
            if (!sb.ready) begin
                beat.argb = $urandom;
            end else if (hit) begin
                // A single flipped bit, often an alpha bit, still counts as a change.
                if ($urandom_range(0, 3) == 0) beat.argb = beat.argb ^ (32'd1 << $urandom_range(0, 31));
                else beat.argb = $urandom;
            end
            beat.last_pixel = (n + 1 == len) || (sb.ready && !sb.written[sb.pixel_index(1'b1)]);
            beat.now_ms     = beat.last_pixel ? stamp : $urandom;
            send_pixel(beat);
            if (beat.last_pixel) break;
        end
    endtask

    // A random frame: mostly whole frames, some cut short, some running past
    // the end and wrapping to row 0. The changed area is usually a tiny box,
    // which steers the policy into deferrals, and sometimes larger or empty.
    task automatic random_frame();
        int unsigned w, h, total, len, kind, r, x0, x1, y0, y1, pct, advance_ms;
        w     = sb.frame_w();
        h     = sb.frame_h();
        total = w * h;
        r     = $urandom_range(0, 9);
        if (r == 0) len = $urandom_range(1, total);
        else if (r == 1) len = total + $urandom_range(1, 2 * w);
        else len = total;

        kind = $urandom_range(0, 9);
        x0   = $urandom_range(0, w - 1);
        y0   = $urandom_range(0, h - 1);
        pct  = (kind == 0) ? 0 : $urandom_range(30, 100);
        if (kind <= 5) begin
            x1 = x0 + $urandom_range(0, 1);
            y1 = y0 + $urandom_range(0, 1);
            if (x1 >= w) x1 = w - 1;
            if (y1 >= h) y1 = h - 1;
        end else if (kind <= 7) begin
            x1 = $urandom_range(x0, w - 1);
            y1 = $urandom_range(y0, h - 1);
        end else begin
            x0 = 0;
            y0 = 0;
            x1 = w - 1;
            y1 = h - 1;
        end

        // Time moves on by less than the interval, around it, barely, or by a
        // huge step that wraps the 32-bit count.
        r = $urandom_range(0, 19);
        if (r < 10) advance_ms = $urandom_range(0, sb.interval_reg);
        else if (r < 16) advance_ms = $urandom_range(sb.interval_reg, sb.interval_reg + 20);
        else if (r < 19) advance_ms = $urandom_range(0, 3);
        else advance_ms = $urandom;
        clock_ms = clock_ms + advance_ms;

        send_frame(len, x0, x1, y0, y1, pct, clock_ms);
    endtask

    // Reconfiguration between phases. Width and height are always written as
    // a pair so that a large width never meets a large height by accident.
    task automatic random_config();
        int unsigned r, w, h;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                w = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(MAX_WIDTH + 1, 511);
                h = $urandom_range(0, 2);
            end else if (r == 1) begin
                h = $urandom_range(0, 1) ? MAX_HEIGHT : $urandom_range(MAX_HEIGHT + 1, 255);
                w = $urandom_range(0, 2);
            end else begin
                w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            end
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_WIDTH, w);
                write_reg(CFG_HEIGHT, h);
            end else begin
                write_reg(CFG_HEIGHT, h);
                write_reg(CFG_WIDTH, w);
            end
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_FLUSH_MODE, ($urandom_range(0, 4) == 0) ? 1 : 0);
        if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 3);
            write_reg(CFG_MIN_INTERVAL, (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 40));
        end
    endtask

    // Result side: pops with random stalls and checks every beat it takes.
    initial begin : result_side
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_gap();
            @(negedge i_clk);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            sb.check_result(o_item);
        end
    end

    initial begin : stimulus
        int unsigned start_count;
        sb          = new();
        idle_on     = 1'b1;
        clock_ms    = 32'd0;
        pixels_sent = 0;
        cycle_count = 0;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_item      = '0;
        i_pop       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_FLUSH_MODE;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size, 320x240. A first frame cut short after two pixels still
        // gives a full refresh, with the flush stamped just below the wrap.
        send_pixel(pixel(32'h0000_0000, 1'b0, 32'h0000_0000));
        send_pixel(pixel(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFF8));
        // Only the alpha byte changes at (1,0): changed, same RGB565, and since
        // just 12 ms have passed across the wrap, the tiny box is deferred.
        send_pixel(pixel(32'h0000_0000, 1'b0, 32'hFFFF_FFFF));
        send_pixel(pixel(32'h7FFF_FFFF, 1'b1, 32'h0000_0004));
        // A clean frame once the interval is over sends the pending box, and
        // a second clean frame then has nothing to do.
        send_pixel(pixel(32'h0000_0000, 1'b1, 32'h0000_0014));
        send_pixel(pixel(32'h0000_0000, 1'b1, 32'h0000_0015));

        // A 4x2 frame: total/8 is one pixel and total/3 two pixels.
        drain();
        write_reg(CFG_WIDTH, 4);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_MIN_INTERVAL, 255);
        write_reg(CFG_FLUSH_MODE, 0);
        send_frame(8, 0, 3, 0, 1, 100, 32'd1000);
        send_pixel(pixel(sb.shadow[0] ^ 32'h0000_0100, 1'b1, 32'd1001));
        // A second small change inside the interval merges into the pending box.
        send_frame(2, 1, 1, 0, 0, 100, 32'd1002);
        // Any register write drops the pending box; full mode refreshes it all.
        drain();
        write_reg(CFG_FLUSH_MODE, 1);
        send_pixel(pixel(sb.shadow[0] ^ 32'h8000_0000, 1'b1, 32'd1003));
        drain();
        write_reg(CFG_FLUSH_MODE, 0);
        write_reg(CFG_MIN_INTERVAL, 0);
        send_pixel(pixel(sb.shadow[0], 1'b1, 32'd1004));
        // Two pixels changed with the interval passed: a plain rectangle.
        send_frame(3, 1, 2, 0, 0, 100, 32'd1005);

        // The widest frame, one row high, twice with no idling: the whole row
        // gets written, then only its rightmost pixel changes.
        drain();
        idle_on = 1'b0;
        write_reg(CFG_WIDTH, MAX_WIDTH);
        write_reg(CFG_HEIGHT, 1);
        clock_ms = $urandom;
        send_frame(MAX_WIDTH, 0, 0, 0, 0, 0, clock_ms);
        send_frame(MAX_WIDTH, MAX_WIDTH - 1, MAX_WIDTH - 1, 0, 0, 100, clock_ms + 32'd1);
        idle_on = 1'b1;

        // Random phases of a few frames each, reconfigured now and then. They
        // start from a small frame so that many frames fit in the run.
        drain();
        write_reg(CFG_WIDTH, 12);
        write_reg(CFG_HEIGHT, 10);
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_BEATS) begin
            if ($urandom_range(0, 2) == 0) begin
                drain();
                random_config();
            end
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) random_frame();
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.error_count == 0 && sb.expected_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/fdr_pkg.sv
src/fdr_front.sv
src/fdr_diff.sv
src/fdr_flush.sv
src/frame_dirty_rect_flush_policy.sv
bench/tb_top.sv
